>>> hdl/hhp_pkg.sv
// Package for the HTTP header byte parser: state, class and error codes,
// byte constants and the result struct. No dependencies.

package hhp_pkg;

  localparam int unsigned OFFSET_W = 10;
  localparam int unsigned STATE_W  = 4;
  localparam int unsigned CLASS_W  = 4;
  localparam int unsigned ERR_W    = 3;

  typedef logic [7:0]          byte_t;
  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [STATE_W-1:0]  state_t;
  typedef logic [CLASS_W-1:0]  class_t;
  typedef logic [ERR_W-1:0]    err_t;

  localparam state_t ST_START  = 4'd0;
  localparam state_t ST_KEY    = 4'd1;
  localparam state_t ST_COLON  = 4'd2;
  localparam state_t ST_SPACE  = 4'd3;
  localparam state_t ST_VALUE  = 4'd4;
  localparam state_t ST_CR     = 4'd5;
  localparam state_t ST_LF     = 4'd6;
  localparam state_t ST_END_CR = 4'd7;

  localparam class_t CL_SKIP  = 4'd0;
  localparam class_t CL_KEY   = 4'd1;
  localparam class_t CL_COLON = 4'd2;
  localparam class_t CL_SPACE = 4'd3;
  localparam class_t CL_VALUE = 4'd4;
  localparam class_t CL_LCR   = 4'd5;
  localparam class_t CL_LLF   = 4'd6;
  localparam class_t CL_ECR   = 4'd7;
  localparam class_t CL_DONE  = 4'd8;
  localparam class_t CL_ERROR = 4'd9;

  localparam err_t ERR_NONE      = 3'd0;
  localparam err_t ERR_KEY_CRLF  = 3'd1;
  localparam err_t ERR_NO_SPACE  = 3'd2;
  localparam err_t ERR_VAL_LONG  = 3'd3;
  localparam err_t ERR_LINE_CR   = 3'd4;
  localparam err_t ERR_END_CR    = 3'd5;

  localparam byte_t BYTE_CR    = 8'h0D;
  localparam byte_t BYTE_LF    = 8'h0A;
  localparam byte_t BYTE_COLON = 8'h3A;
  localparam byte_t BYTE_SP    = 8'h20;

  localparam offset_t MAX_VALUE_OFFSET_RST = 10'd255;

  typedef struct packed {
    class_t byte_class;
    byte_t  byte_echo;
    err_t   error_code;
  } result_t;

endpackage

>>> hdl/hhp_in_if.sv
// Input channel of the HTTP header byte parser: valid/ready plus one byte.
// Depends on hhp_pkg.

interface hhp_in_if;
  logic            valid;
  logic            ready;
  hhp_pkg::byte_t  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

>>> hdl/hhp_out_if.sv
// Result channel of the HTTP header byte parser: valid/ready plus class,
// echoed byte and error code. Depends on hhp_pkg.

interface hhp_out_if;
  logic            valid;
  logic            ready;
  hhp_pkg::class_t byte_class;
  hhp_pkg::byte_t  byte_echo;
  hhp_pkg::err_t   error_code;

  modport source (output valid, output byte_class, output byte_echo, output error_code,
                  input ready);
  modport sink   (input valid, input byte_class, input byte_echo, input error_code,
                  output ready);
endinterface

>>> hdl/hhp_classifier.sv
// Parse state machine: classifies one byte against the current state and
// updates state and value offset on advance. Depends on hhp_pkg.

module hhp_classifier (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  hhp_pkg::byte_t   data_byte,
  input  hhp_pkg::offset_t max_value_offset,
  output hhp_pkg::result_t res
);
  import hhp_pkg::*;

  state_t  state_r, state_nxt;
  offset_t offset_r, offset_nxt;
  class_t  cls;
  err_t    err;
  logic [OFFSET_W:0] offset_inc;
  logic    is_crlf;

  assign offset_inc = {1'b0, offset_r} + {{OFFSET_W{1'b0}}, 1'b1};
  assign is_crlf    = (data_byte == BYTE_CR) || (data_byte == BYTE_LF);

  always_comb begin
    cls        = CL_SKIP;
    err        = ERR_NONE;
    state_nxt  = state_r;
    offset_nxt = offset_r;
    unique case (state_r)
      ST_KEY: begin
        if (data_byte == BYTE_COLON) begin
          cls       = CL_COLON;
          state_nxt = ST_COLON;
        end else if (is_crlf) begin
          err = ERR_KEY_CRLF;
        end else begin
          cls = CL_KEY;
        end
      end
      ST_COLON: begin
        if (data_byte == BYTE_SP) begin
          cls       = CL_SPACE;
          state_nxt = ST_SPACE;
        end else begin
          err = ERR_NO_SPACE;
        end
      end
      ST_SPACE: begin
        cls        = CL_VALUE;
        offset_nxt = '0;
        state_nxt  = ST_VALUE;
      end
      ST_VALUE: begin
        if (data_byte == BYTE_CR) begin
          cls       = CL_LCR;
          state_nxt = ST_CR;
        end else if (offset_inc > {1'b0, max_value_offset}) begin
          err = ERR_VAL_LONG;
        end else begin
          cls        = CL_VALUE;
          offset_nxt = offset_inc[OFFSET_W-1:0];
        end
      end
      ST_CR: begin
        if (data_byte == BYTE_LF) begin
          cls       = CL_LLF;
          state_nxt = ST_LF;
        end else begin
          err = ERR_LINE_CR;
        end
      end
      ST_LF: begin
        if (data_byte == BYTE_CR) begin
          cls       = CL_ECR;
          state_nxt = ST_END_CR;
        end else begin
          cls       = CL_KEY;
          state_nxt = ST_KEY;
        end
      end
      ST_END_CR: begin
        if (data_byte == BYTE_LF) begin
          cls        = CL_DONE;
          state_nxt  = ST_START;
          offset_nxt = '0;
        end else begin
          err = ERR_END_CR;
        end
      end
      default: begin
        if (is_crlf) begin
          cls       = CL_SKIP;
          state_nxt = ST_START;
        end else begin
          cls       = CL_KEY;
          state_nxt = ST_KEY;
        end
      end
    endcase
    if (err != ERR_NONE) begin
      cls        = CL_ERROR;
      state_nxt  = ST_START;
      offset_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_START;
      offset_r <= '0;
    end else if (advance) begin
      state_r  <= state_nxt;
      offset_r <= offset_nxt;
    end
  end

  assign res.byte_class = cls;
  assign res.byte_echo  = data_byte;
  assign res.error_code = err;

  a_err_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (cls == CL_ERROR) |=> (state_r == ST_START) && (offset_r == '0))
    else $error("error item did not return parser to start");

  a_code_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (cls != CL_ERROR) |-> (err == ERR_NONE))
    else $error("error code set on non-error item");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r) && $stable(offset_r))
    else $error("parse state moved without an item");

  a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (cls == CL_DONE) |=> (state_r == ST_START))
    else $error("headers done did not return parser to start");
endmodule

>>> hdl/http_header_byte_parser_top.sv
// Top level of the HTTP header byte parser: input register, classifier and
// result register. Depends on hhp_pkg, hhp_in_if, hhp_out_if, hhp_classifier.
//
//   channel  | dir | fields
//   in_ch    | in  | data_byte[7:0]
//   out_ch   | out | byte_class[3:0], byte_echo[7:0], error_code[2:0]
//   cfg      | in  | cfg_we, cfg_wdata[9:0] (max_value_offset)
//
// One item per cycle while out_ch.ready holds; items pass input then result register.
// The input register feeds the classifier, whose state updates as the item moves
// into the result register. A stalled result register backs up the input register;
// in_ch.ready stays high while either stage has room. Synchronous active-low
// reset clears the parse state, both valid flags and sets max_value_offset to 255.

module http_header_byte_parser_top (
  input  logic                   clk,
  input  logic                   rst_n,
  hhp_in_if.sink                 in_ch,
  hhp_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  hhp_pkg::offset_t       cfg_wdata
);
  import hhp_pkg::*;

  logic    s1_valid_r;
  byte_t   s1_byte_r;
  logic    out_valid_r;
  result_t out_res_r;
  offset_t max_off_r;
  result_t cls_res;
  logic    s2_room;
  logic    advance;
  logic    in_take;

  assign s2_room  = !out_valid_r || out_ch.ready;
  assign advance  = s1_valid_r && s2_room;
  assign in_ch.ready = !s1_valid_r || s2_room;
  assign in_take  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_off_r <= MAX_VALUE_OFFSET_RST;
    end else if (cfg_we) begin
      max_off_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_ch.data_byte;
    end
  end

  hhp_classifier u_classifier (
    .clk              (clk),
    .rst_n            (rst_n),
    .advance          (advance),
    .data_byte        (s1_byte_r),
    .max_value_offset (max_off_r),
    .res              (cls_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_room) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= cls_res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.byte_class = out_res_r.byte_class;
  assign out_ch.byte_echo  = out_res_r.byte_echo;
  assign out_ch.error_code = out_res_r.error_code;
endmodule
